>>> rtl/core/swf_pkg.sv
package swf_pkg;

    localparam int TAP_COUNT = 64;
    localparam int TAP_W     = 6;
    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 8;
    localparam int PROD_W    = SAMPLE_W + COEF_W;
    // The sum of the coefficient magnitudes is 458, so 25 signed bits always hold the sum.
    localparam int ACC_W     = 25;
    localparam int SUM_SHIFT = 6;

    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-32768);

    // Entry 0 meets the oldest sample, and the last entry meets the newest.
    localparam logic signed [COEF_W-1:0] COEF_TABLE [TAP_COUNT] = '{
          8'sd4,  -8'sd6,   8'sd4, -8'sd11,  -8'sd1,  -8'sd5,   8'sd3,   8'sd3,
         -8'sd2,   8'sd5,  -8'sd5,   8'sd0,   8'sd9,   8'sd1,   8'sd6,   8'sd3,
         -8'sd4,  -8'sd1,  -8'sd5,  -8'sd3,  -8'sd2,  -8'sd5,  -8'sd7,   8'sd1,
          8'sd6,  -8'sd7,  8'sd30, -8'sd29,  8'sd12,  -8'sd3, -8'sd11,   8'sd4,
         -8'sd3,   8'sd7, -8'sd20,  8'sd23,   8'sd2,   8'sd0,   8'sd1,  -8'sd6,
        -8'sd14,  -8'sd5,  8'sd15, -8'sd18,   8'sd6,   8'sd7,  8'sd15, -8'sd10,
        -8'sd14,  8'sd22,  -8'sd7,  -8'sd2,  -8'sd4,   8'sd9,   8'sd6, -8'sd12,
          8'sd6,  -8'sd6,   8'sd0, -8'sd11,   8'sd0,  -8'sd5,   8'sd4,   8'sd0
    };

    typedef struct packed {
        logic clear;
        logic enable;
    } mac_ctrl_t;

endpackage

>>> rtl/core/swf_hist_ram.sv
module swf_hist_ram
    import swf_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr_en,
    input  logic [TAP_W-1:0]           wr_addr,
    input  logic signed [SAMPLE_W-1:0] wr_data,
    input  logic [TAP_W-1:0]           rd_addr,
    output logic signed [SAMPLE_W-1:0] rd_data
);

    logic signed [SAMPLE_W-1:0] mem [TAP_COUNT];
    logic [TAP_COUNT-1:0]       valid_reg;
    logic signed [SAMPLE_W-1:0] rd_data_reg;
    logic                       rd_valid_reg;

    // Entries not yet written since reset read as zero history.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= valid_reg[rd_addr];
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

>>> rtl/core/swf_mac.sv
module swf_mac
    import swf_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  mac_ctrl_t                  ctrl,
    input  logic signed [SAMPLE_W-1:0] data,
    input  logic signed [COEF_W-1:0]   coef,
    output logic signed [ACC_W-1:0]    acc
);

    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_en_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    // The product is registered before it is added, so the unit has two stages.
    always_ff @(posedge clk)
    begin
        prod_reg <= data * coef;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_en_reg <= 1'b0;
            acc_reg     <= '0;
        end
        else
        begin
            prod_en_reg <= ctrl.enable;
            if (ctrl.clear)
            begin
                acc_reg <= '0;
            end
            else if (prod_en_reg)
            begin
                acc_reg <= acc_reg + ACC_W'(prod_reg);
            end
        end
    end

    assign acc = acc_reg;

endmodule

>>> rtl/core/stereo_widening_fir64_top.sv
// Stereo widening filter: a 64-tap FIR with fixed signed 8-bit coefficients over an
// interleaved stereo stream of signed 16-bit samples. Each request carries one sample
// and a block-end mark; each produces exactly one result, the sum of the last 64
// samples (oldest against the first coefficient) shifted arithmetically right by 6
// and saturated to signed 16 bits, with the block-end mark copied alongside. The
// history starts as zeros after reset and runs on across block boundaries. One
// multiplier is shared over all taps under a small sequencer: an accepted request
// goes through the tap reads from the history memory, a drain while the last product
// and sum settle after the final read, and the load of the output register. in_stall
// stays high for that whole time, so a new request is accepted only after the
// previous result has been loaded. While an earlier result still blocks the output
// register, the load waits and in_stall stays high longer. The next request may be
// accepted while the previous result still waits for the downstream side.
// No clearing pass is needed after reset; per-entry valid bits stand in for it.
module stereo_widening_fir64_top
    import swf_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic signed [SAMPLE_W-1:0] sample_in,
    input  logic                       end_of_block,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [SAMPLE_W-1:0] sample_out,
    output logic                       last_of_block
);

    // Sequencer states, one-hot.
    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_RUN    = 4'b0010,
        S_DRAIN  = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    state_t                     state_reg;
    state_t                     state_next;
    logic [TAP_W-1:0]           tap_reg;
    logic [TAP_W-1:0]           tap_next;
    logic [TAP_W-1:0]           wptr_reg;
    logic [TAP_W-1:0]           wptr_next;
    logic                       drain_reg;
    logic                       drain_next;
    logic                       rd_issue_reg;
    logic signed [COEF_W-1:0]   coef_reg;
    logic                       eob_reg;
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] sample_out_reg;
    logic                       last_reg;

    logic                       accept;
    logic                       load_out;
    logic [TAP_W-1:0]           rd_addr;
    logic signed [SAMPLE_W-1:0] rd_data;
    logic signed [ACC_W-1:0]    acc;
    logic signed [ACC_W-1:0]    shifted;
    logic signed [SAMPLE_W-1:0] sat_value;
    mac_ctrl_t                  mac_ctrl;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;

    // The result register is free when empty or when its contents leave this cycle.
    assign load_out = (state_reg == S_FINISH) && (!out_valid_reg || !out_stall);

    // The new sample sits at the write pointer; tap 0 reads the slot after it, which
    // holds the sample from 63 requests ago, and tap 63 reads the new sample itself.
    assign rd_addr = wptr_reg + TAP_W'(1) + tap_reg;

    always_comb
    begin
        state_next = state_reg;
        tap_next   = tap_reg;
        wptr_next  = wptr_reg;
        drain_next = drain_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_RUN;
                    tap_next   = '0;
                end
            end
            S_RUN:
            begin
                tap_next = tap_reg + TAP_W'(1);
                if (tap_reg == TAP_W'(TAP_COUNT - 1))
                begin
                    state_next = S_DRAIN;
                    drain_next = 1'b0;
                end
            end
            S_DRAIN:
            begin
                // The drain waits while the last product passes the multiplier and adder.
                drain_next = 1'b1;
                if (drain_reg)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                    wptr_next  = wptr_reg + TAP_W'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tap_reg       <= '0;
            wptr_reg      <= '0;
            drain_reg     <= 1'b0;
            rd_issue_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            tap_reg      <= tap_next;
            wptr_reg     <= wptr_next;
            drain_reg    <= drain_next;
            rd_issue_reg <= (state_reg == S_RUN);
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // The coefficient is delayed to line up with the registered memory read.
    always_ff @(posedge clk)
    begin
        coef_reg <= COEF_TABLE[tap_reg];
        if (accept)
        begin
            eob_reg <= end_of_block;
        end
        if (load_out)
        begin
            sample_out_reg <= sat_value;
            last_reg       <= eob_reg;
        end
    end

    // Arithmetic shift rounds toward minus infinity, then the value is clipped.
    assign shifted = acc >>> SUM_SHIFT;

    always_comb
    begin
        if (shifted > SAT_HI)
        begin
            sat_value = SAMPLE_W'(SAT_HI);
        end
        else if (shifted < SAT_LO)
        begin
            sat_value = SAMPLE_W'(SAT_LO);
        end
        else
        begin
            sat_value = SAMPLE_W'(shifted);
        end
    end

    assign mac_ctrl.clear  = accept;
    assign mac_ctrl.enable = rd_issue_reg;

    swf_hist_ram u_hist_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept),
        .wr_addr (wptr_reg),
        .wr_data (sample_in),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    swf_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (mac_ctrl),
        .data  (rd_data),
        .coef  (coef_reg),
        .acc   (acc)
    );

    assign out_valid     = out_valid_reg;
    assign sample_out    = sample_out_reg;
    assign last_of_block = last_reg;

endmodule

>>> test/tb_stereo_widening_fir64_top.sv
module tb_stereo_widening_fir64_top;
    import swf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // The random stream stops once this many requests have been sent.
    localparam int STREAM_ITEMS = 1200;
    // Cycles without any request or result being taken before the run is abandoned. Take the
    // time one request occupies the block, add the longest sender gap and the longest
    // receiver stall run, then allow a generous margin on top.
    localparam int IDLE_LIMIT   = 4000;
    // Cycles allowed after the last result, a little more than one request's latency.
    localparam int DRAIN_CYCLES = 80;
    // The receiver never stalls for longer than this many cycles in a row.
    localparam int MAX_STALL_RUN = 8;

    typedef enum int {
        STALL_NEVER,
        STALL_COIN,
        STALL_PERIODIC,
        STALL_HEAVY
    } stall_mode_t;

    typedef enum int {
        SEG_FULL_RANGE,
        SEG_SMALL,
        SEG_CORNERS,
        SEG_SIGN_MATCHED,
        SEG_STEP,
        SEG_DRAIN
    } segment_t;

    typedef struct {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } filtered_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic signed [SAMPLE_W-1:0] sample_in = '0;
    logic                       end_of_block = 1'b0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       last_of_block;

    // Our own copy of the filter's delay line: entry 0 holds the oldest sample.
    logic signed [SAMPLE_W-1:0] history [TAP_COUNT-1];

    // Filtered samples that the block still owes us, oldest first.
    filtered_t filtered_q [$];

    int          mismatch_count = 0;
    int          requests_sent = 0;
    int          burst_left = 0;
    int          gap_max = 0;
    stall_mode_t stall_mode = STALL_NEVER;
    int          stall_run = 0;
    int          stall_phase = 0;
    int          quiet_cycles = 0;

    stereo_widening_fir64_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample_in    (sample_in),
        .end_of_block (end_of_block),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .sample_out   (sample_out),
        .last_of_block(last_of_block)
    );

    // The clock spends 1 ns high and 1 ns low.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Runs one sample through the filter: the new sample meets the last coefficient and
    // the oldest sample in the history meets the first. The sum is floored by the shift
    // (an arithmetic shift of a signed int) and then clipped to 16 bits. The history then
    // moves along by one place.
    function automatic filtered_t filter_sample(logic signed [SAMPLE_W-1:0] x, logic eob);
        int        acc;
        int        shifted;
        filtered_t r;
        acc = 0;
        for (int j = 0; j < TAP_COUNT - 1; j++)
        begin
            acc += int'(history[j]) * int'(COEF_TABLE[j]);
        end
        acc += int'(x) * int'(COEF_TABLE[TAP_COUNT-1]);
        shifted = acc >>> SUM_SHIFT;
        if (shifted > 32767)
        begin
            shifted = 32767;
        end
        else if (shifted < -32768)
        begin
            shifted = -32768;
        end
        for (int j = 0; j < TAP_COUNT - 2; j++)
        begin
            history[j] = history[j+1];
        end
        history[TAP_COUNT-2] = x;
        r.sample = SAMPLE_W'(shifted);
        r.last   = eob;
        return r;
    endfunction

    // Sends one request. The sender works in bursts: when a burst runs out, valid drops
    // for a random gap (possibly none) and a new burst length is drawn. The payload is
    // held steady until the block takes it, and the expected result is queued at the
    // very edge at which the request is accepted.
    task automatic send_sample(logic signed [SAMPLE_W-1:0] x, logic eob);
        int gap;
        if (burst_left == 0)
        begin
            gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        @(negedge clk);
        in_valid     <= 1'b1;
        sample_in    <= x;
        end_of_block <= eob;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        filtered_q.push_back(filter_sample(x, eob));
        requests_sent++;
    endtask

    // Holds the sender back until every outstanding result has come out of the block.
    task automatic wait_for_drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (filtered_q.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    function automatic logic random_mark();
        return ($urandom_range(0, 7) == 0);
    endfunction

    // Picks a stall pattern for the receiver and a gap length for the sender, so that
    // idle cycles land on every phase of the block's work over the run.
    task automatic shuffle_idling();
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        case ($urandom_range(0, 2))
            0: gap_max = 0;
            1: gap_max = 3;
            default: gap_max = 40;
        endcase
    endtask

    // Sends a window of 64 samples whose signs follow the coefficient signs, which drives
    // the sum as far as it can go. With a negative polarity the signs are inverted and the
    // sum heads for the negative limit. Zero coefficients get random samples.
    task automatic send_sign_matched(int unsigned mag, logic negative);
        logic signed [SAMPLE_W-1:0] x;
        logic signed [SAMPLE_W-1:0] m;
        m = SAMPLE_W'(mag);
        for (int j = 0; j < TAP_COUNT; j++)
        begin
            if (COEF_TABLE[j] == 0)
            begin
                x = SAMPLE_W'($urandom);
            end
            else
            begin
                x = (COEF_TABLE[j] > 0) ? m : ~m;
                if (negative)
                begin
                    x = ~x;
                end
            end
            send_sample(x, random_mark());
        end
    endtask

    // Straight after reset the history is all zeros, so the first results see only the
    // samples sent so far. The full-scale values, the values around zero and alternating
    // bit patterns go through here, and the block-end mark takes both values, including
    // twice in a row.
    task automatic test_start_from_reset();
        logic signed [SAMPLE_W-1:0] corner [14];
        corner = '{16'sh7fff, -16'sh8000, 16'sh0000, -16'sh0001, 16'sh0001, 16'sh7fff,
                   16'sh7fff, -16'sh8000, -16'sh8000, 16'sh5555, -16'sh5556, 16'sh0000,
                   16'sh4000, -16'sh4000};
        stall_mode = STALL_NEVER;
        gap_max    = 0;
        for (int i = 0; i < 14; i++)
        begin
            send_sample(corner[i], (i % 3) != 1);
        end
        stall_mode = STALL_HEAVY;
        wait_for_drain();
    endtask

    // Drives the accumulator into saturation at both limits, with full-scale windows and
    // with random large magnitudes that all lie beyond the clipping point.
    task automatic test_saturation();
        shuffle_idling();
        send_sign_matched(32767, 1'b0);
        send_sign_matched(32767, 1'b1);
        shuffle_idling();
        send_sign_matched($urandom_range(7000, 32767), 1'b0);
        send_sign_matched($urandom_range(7000, 32767), 1'b1);
        wait_for_drain();
    endtask

    // The bulk of the run: segments of different character, each under its own idle
    // pattern. Filtering carries on across the segments, so each segment begins with the
    // tail of the previous one still in the delay line.
    task automatic test_random_stream();
        segment_t seg;
        int       len;
        int       step_value;
        while (requests_sent < STREAM_ITEMS)
        begin
            shuffle_idling();
            seg = segment_t'($urandom_range(0, 5));
            len = $urandom_range(10, 40);
            case (seg)
                SEG_FULL_RANGE:
                begin
                    repeat (len) send_sample(SAMPLE_W'($urandom), random_mark());
                end
                SEG_SMALL:
                begin
                    repeat (len)
                    begin
                        send_sample(SAMPLE_W'($urandom_range(0, 16)) - 16'sd8,
                                    random_mark());
                    end
                end
                SEG_CORNERS:
                begin
                    repeat (len)
                    begin
                        case ($urandom_range(0, 4))
                            0: send_sample(16'sh7fff, random_mark());
                            1: send_sample(-16'sh8000, random_mark());
                            2: send_sample(16'sh0000, random_mark());
                            3: send_sample(-16'sh0001, random_mark());
                            default: send_sample(16'sh0001, random_mark());
                        endcase
                    end
                end
                SEG_SIGN_MATCHED:
                begin
                    send_sign_matched($urandom_range(0, 32767), 1'($urandom_range(0, 1)));
                end
                SEG_STEP:
                begin
                    // A constant input settles to the DC gain of the filter.
                    step_value = $urandom;
                    repeat (TAP_COUNT + 6) send_sample(SAMPLE_W'(step_value), random_mark());
                end
                default:
                begin
                    wait_for_drain();
                    repeat (len) send_sample(SAMPLE_W'($urandom), random_mark());
                end
            endcase
        end
    endtask

    // The receiver decides its stall at each falling edge, following the current pattern,
    // and never stalls for more than a few cycles in a row.
    always @(negedge clk)
    begin
        logic stall_next;
        case (stall_mode)
            STALL_NEVER:    stall_next = 1'b0;
            STALL_COIN:     stall_next = 1'($urandom_range(0, 1));
            STALL_PERIODIC: stall_next = (stall_phase % 5) < 3;
            default:        stall_next = ($urandom_range(0, 3) != 0);
        endcase
        if (stall_next && stall_run >= MAX_STALL_RUN)
        begin
            stall_next = 1'b0;
        end
        stall_run = stall_next ? stall_run + 1 : 0;
        stall_phase++;
        out_stall <= stall_next;
    end

    // Every result taken at a rising edge is matched against the oldest expectation.
    always @(posedge clk)
    begin
        filtered_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (filtered_q.size() == 0)
            begin
                $display("%0t: result with nothing expected: sample_out %0d last_of_block %0b",
                         $time, sample_out, last_of_block);
                mismatch_count++;
            end
            else
            begin
                want = filtered_q.pop_front();
                if (sample_out !== want.sample)
                begin
                    $display("%0t: sample_out expected %0d actual %0d",
                             $time, want.sample, sample_out);
                    mismatch_count++;
                end
                if (last_of_block !== want.last)
                begin
                    $display("%0t: last_of_block expected %0b actual %0b",
                             $time, want.last, last_of_block);
                    mismatch_count++;
                end
            end
        end
    end

    // The watchdog restarts its count on every accepted request or result; a block that
    // stops moving altogether ends the run as a failure.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial
    begin
        for (int j = 0; j < TAP_COUNT - 1; j++)
        begin
            history[j] = '0;
        end
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_start_from_reset();
        test_saturation();
        test_random_stream();

        // Everything has been sent; wait for the last results, then give the block a
        // little longer in case it produces anything it should not.
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && filtered_q.size() == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
